// ----- src/wrts_pkg.sv -----
package wrts_pkg;

    // operand / destination selects of the arithmetic program
    typedef enum logic [3:0] {
        SRC_N,
        SRC_NM2,
        SRC_SX,
        SRC_SXX,
        SRC_SY,
        SRC_SXY,
        SRC_SYY,
        SRC_DD,
        SRC_P,
        SRC_Q,
        SRC_T1,
        SRC_T2,
        SRC_NN
    } t_src;

    typedef enum logic {
        KIND_MUL,
        KIND_SUB
    } t_kind;

    // what the sequencer does once an operation has written its result
    typedef enum logic [1:0] {
        AFT_NEXT,
        AFT_ZERO_CHECK,
        AFT_ROOT_INTERCEPT,
        AFT_ROOT_SLOPE
    } t_after;

    typedef struct packed {
        t_kind  kind;
        t_src   dst;
        t_src   a;
        t_src   b;
        t_after after;
    } t_uop;

    localparam int          UOP_W         = 5;
    localparam logic [7:0]  FIT_LEN_RESET = 8'd101;
    localparam logic [7:0]  MIN_FIT       = 8'd3;

    // Program for the normal equations. For a multiply, b is the narrower
    // operand: the shift-add unit runs one step per significant bit of b.
    function automatic t_uop uop_at(input logic [UOP_W-1:0] idx);
        t_uop u;
        u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_SXX, b: SRC_N, after: AFT_NEXT};
        case (idx)
            5'd0:  u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_SXX, b: SRC_N,   after: AFT_NEXT};
            5'd1:  u = '{kind: KIND_MUL, dst: SRC_T2, a: SRC_SX,  b: SRC_SX,  after: AFT_NEXT};
            5'd2:  u = '{kind: KIND_SUB, dst: SRC_DD, a: SRC_T1,  b: SRC_T2,  after: AFT_NEXT};
            5'd3:  u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_SXY, b: SRC_N,   after: AFT_NEXT};
            5'd4:  u = '{kind: KIND_MUL, dst: SRC_T2, a: SRC_SY,  b: SRC_SX,  after: AFT_NEXT};
            5'd5:  u = '{kind: KIND_SUB, dst: SRC_P,  a: SRC_T1,  b: SRC_T2,  after: AFT_NEXT};
            5'd6:  u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_SY,  b: SRC_SXX, after: AFT_NEXT};
            5'd7:  u = '{kind: KIND_MUL, dst: SRC_T2, a: SRC_SXY, b: SRC_SX,  after: AFT_NEXT};
            5'd8:  u = '{kind: KIND_SUB, dst: SRC_Q,  a: SRC_T1,  b: SRC_T2,  after: AFT_NEXT};
            5'd9:  u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_SYY, b: SRC_N,   after: AFT_NEXT};
            5'd10: u = '{kind: KIND_MUL, dst: SRC_T2, a: SRC_SY,  b: SRC_SY,  after: AFT_NEXT};
            5'd11: u = '{kind: KIND_SUB, dst: SRC_T1, a: SRC_T1,  b: SRC_T2,  after: AFT_NEXT};
            5'd12: u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_T1,  b: SRC_DD,  after: AFT_NEXT};
            5'd13: u = '{kind: KIND_MUL, dst: SRC_T2, a: SRC_P,   b: SRC_P,   after: AFT_NEXT};
            5'd14: u = '{kind: KIND_SUB, dst: SRC_NN, a: SRC_T1,  b: SRC_T2,
                         after: AFT_ZERO_CHECK};
            5'd15: u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_Q,   b: SRC_Q,   after: AFT_NEXT};
            5'd16: u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_T1,  b: SRC_NM2, after: AFT_NEXT};
            5'd17: u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_T1,  b: SRC_N,   after: AFT_NEXT};
            5'd18: u = '{kind: KIND_MUL, dst: SRC_T2, a: SRC_NN,  b: SRC_SXX,
                         after: AFT_ROOT_INTERCEPT};
            5'd19: u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_P,   b: SRC_P,   after: AFT_NEXT};
            5'd20: u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_T1,  b: SRC_NM2,
                         after: AFT_ROOT_SLOPE};
            default: u = '{kind: KIND_MUL, dst: SRC_T1, a: SRC_SXX, b: SRC_N,
                           after: AFT_NEXT};
        endcase
        return u;
    endfunction

endpackage

// ----- src/window_regression_t_statistics.sv -----
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------------------------
// sample    | in        | i_valid / o_stall  | i_likelihood_sample
// result    | out       | o_valid / i_stall  | o_t_intercept, o_t_slope, o_perfect_fit
// config    | in        | i_cfg_wr_en        | i_cfg_wr_data (fit_length)
//
// While the window fills, a sample is written to the RAM and gives no result.
// A full window is summed out of the sample RAM; then up to 21 program steps run
// on one shift-add multiplier (one step per significant bit of the narrow operand),
// then per statistic a load step, 64 divider steps and 32 root steps, unless the
// quotient saturates in the load step.
// Reset is synchronous; the sample RAM is not cleared. A stalled result sits in the
// output register while the next sample is taken.
module window_regression_t_statistics #(
    parameter int MAX_WINDOW = 128,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_likelihood_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_t_intercept,
    output logic [31:0] o_t_slope,
    output logic        o_perfect_fit,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    localparam int LW   = $clog2(MAX_WINDOW + 1);
    localparam int PW   = $clog2(MAX_WINDOW);
    localparam int CW   = (LW > 8) ? LW + 1 : 9;
    localparam int WY   = 32 + LW;
    localparam int WXY  = 32 + 2 * LW;
    localparam int WYY  = 62 + LW;
    localparam int WSX  = 2 * LW;
    localparam int WSXX = 3 * LW;
    localparam int WD   = 66 + 10 * LW;
    localparam int SH   = 64 - 2 * FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_LOAD,
        ST_MUL,
        ST_ROOT_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_state;

    t_state r_state;

    // configuration and window bookkeeping
    logic [7:0]    r_fit_len;
    logic [LW-1:0] r_fill;
    logic [PW-1:0] r_wptr;
    logic [LW-1:0] r_n;

    // sample RAM
    logic [31:0]   r_mem [MAX_WINDOW];
    logic [31:0]   r_rd_data;
    logic [PW-1:0] r_raddr;
    logic          w_rd_en;
    logic          w_accept;

    // window sums
    logic [LW-1:0]   r_left;
    logic [LW-1:0]   r_k;
    logic [WSX-1:0]  r_xsq;
    logic [WSX-1:0]  r_sx;
    logic [WSXX-1:0] r_sxx;
    logic            r_v1;
    logic            r_v2;
    logic [31:0]     r_y2;
    logic [63:0]     r_sq;
    logic [WY-1:0]   r_sy;
    logic [WXY-1:0]  r_sxy;
    logic [WYY-1:0]  r_syy;

    // wide work registers
    logic [WD-1:0] r_dd, r_p, r_q, r_t1, r_t2, r_nn;

    // program sequencer and multiplier
    logic [wrts_pkg::UOP_W-1:0] r_op;
    wrts_pkg::t_uop             w_uop;
    logic [WD-1:0] r_ma, r_mb, r_mp;
    logic          r_mneg;

    // divider and square root
    logic          r_root_sel;
    logic [WD-1:0] r_rem;
    logic [63:0]   r_dlo;
    logic [63:0]   r_quo;
    logic [63:0]   r_sv;
    logic [63:0]   r_sres;
    logic [63:0]   r_sbit;
    logic [6:0]    r_cnt;

    // results waiting for the output register
    logic [31:0] r_ti, r_ts;
    logic        r_pf;
    logic        r_out_valid;
    logic [31:0] r_out_ti, r_out_ts;
    logic        r_out_pf;

    logic [CW-1:0] w_fl_ext;
    logic [LW-1:0] w_neff;
    logic [LW-1:0] n_fill;
    logic [PW-1:0] n_wptr;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_t_intercept = r_out_ti;
    assign o_t_slope     = r_out_ts;
    assign o_perfect_fit = r_out_pf;

    // effective window length, clamped to the legal range
    assign w_fl_ext = CW'(r_fit_len);
    always_comb begin
        if (w_fl_ext < CW'(wrts_pkg::MIN_FIT)) begin
            w_neff = LW'(wrts_pkg::MIN_FIT);
        end else if (w_fl_ext > CW'(MAX_WINDOW)) begin
            w_neff = LW'(MAX_WINDOW);
        end else begin
            w_neff = w_fl_ext[LW-1:0];
        end
    end

    assign n_fill = (r_fill == LW'(MAX_WINDOW)) ? r_fill : r_fill + LW'(1);
    assign n_wptr = (r_wptr == PW'(MAX_WINDOW - 1)) ? '0 : r_wptr + PW'(1);

    // sample RAM: written on transfer, read newest to oldest while summing
    assign w_rd_en = (r_state == ST_ACC) && (r_left != '0);
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wptr] <= i_likelihood_sample;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_raddr];
        end
    end

    // window sum datapath; positions are walked from x = n down to x = 1,
    // so the running sum of y is a suffix sum and adding it builds sum x*y
    logic signed [63:0] w_sq;
    logic [WY-1:0]      w_sy_new;
    logic [LW-1:0]      n_k;
    logic [WSX-1:0]     n_xsq;
    assign w_sq     = $signed(r_rd_data) * $signed(r_rd_data);
    assign w_sy_new = r_sy + {{(WY - 32){r_y2[31]}}, r_y2};
    assign n_k      = r_k + LW'(1);
    assign n_xsq    = r_xsq + WSX'({r_k, 1'b1});

    // operands, extended to the work width: sy and sxy by sign, the rest by zeros
    logic [WD-1:0] w_ext_sy, w_ext_sxy, w_ext_syy, w_ext_sx, w_ext_sxx;
    logic [WD-1:0] w_ext_n, w_ext_nm2;
    assign w_ext_sy  = {{(WD - WY){r_sy[WY-1]}}, r_sy};
    assign w_ext_sxy = {{(WD - WXY){r_sxy[WXY-1]}}, r_sxy};
    assign w_ext_syy = WD'(r_syy);
    assign w_ext_sx  = WD'(r_sx);
    assign w_ext_sxx = WD'(r_sxx);
    assign w_ext_n   = WD'(r_n);
    assign w_ext_nm2 = WD'(r_n - LW'(2));

    function automatic logic [WD-1:0] pick(
        input wrts_pkg::t_src s,
        input logic [WD-1:0] v_n, input logic [WD-1:0] v_nm2,
        input logic [WD-1:0] v_sx, input logic [WD-1:0] v_sxx,
        input logic [WD-1:0] v_sy, input logic [WD-1:0] v_sxy,
        input logic [WD-1:0] v_syy, input logic [WD-1:0] v_dd,
        input logic [WD-1:0] v_p, input logic [WD-1:0] v_q,
        input logic [WD-1:0] v_t1, input logic [WD-1:0] v_t2,
        input logic [WD-1:0] v_nn);
        logic [WD-1:0] v;
        case (s)
            wrts_pkg::SRC_N:   v = v_n;
            wrts_pkg::SRC_NM2: v = v_nm2;
            wrts_pkg::SRC_SX:  v = v_sx;
            wrts_pkg::SRC_SXX: v = v_sxx;
            wrts_pkg::SRC_SY:  v = v_sy;
            wrts_pkg::SRC_SXY: v = v_sxy;
            wrts_pkg::SRC_SYY: v = v_syy;
            wrts_pkg::SRC_DD:  v = v_dd;
            wrts_pkg::SRC_P:   v = v_p;
            wrts_pkg::SRC_Q:   v = v_q;
            wrts_pkg::SRC_T1:  v = v_t1;
            wrts_pkg::SRC_T2:  v = v_t2;
            wrts_pkg::SRC_NN:  v = v_nn;
            default:           v = '0;
        endcase
        return v;
    endfunction

    logic [WD-1:0] w_a, w_b, w_abs_a, w_abs_b;
    assign w_uop = wrts_pkg::uop_at(r_op);
    assign w_a = pick(w_uop.a, w_ext_n, w_ext_nm2, w_ext_sx, w_ext_sxx, w_ext_sy,
                      w_ext_sxy, w_ext_syy, r_dd, r_p, r_q, r_t1, r_t2, r_nn);
    assign w_b = pick(w_uop.b, w_ext_n, w_ext_nm2, w_ext_sx, w_ext_sxx, w_ext_sy,
                      w_ext_sxy, w_ext_syy, r_dd, r_p, r_q, r_t1, r_t2, r_nn);
    assign w_abs_a = w_a[WD-1] ? (~w_a + WD'(1)) : w_a;
    assign w_abs_b = w_b[WD-1] ? (~w_b + WD'(1)) : w_b;

    // completion of one program step: subtract in the load cycle, or the
    // shift-add multiply once the multiplier bits run out
    logic          w_op_done;
    logic [WD-1:0] w_op_res;
    always_comb begin
        w_op_done = 1'b0;
        w_op_res  = '0;
        if ((r_state == ST_LOAD) && (w_uop.kind == wrts_pkg::KIND_SUB)) begin
            w_op_done = 1'b1;
            w_op_res  = w_a - w_b;
        end else if ((r_state == ST_MUL) && (r_mb == '0)) begin
            w_op_done = 1'b1;
            w_op_res  = r_mneg ? (~r_mp + WD'(1)) : r_mp;
        end
    end

    // divider: den is the selected statistic's denominator
    logic [WD-1:0] w_den, w_hi;
    logic [WD:0]   w_trial_div, w_div_diff;
    logic          w_div_ge;
    assign w_den       = r_root_sel ? r_nn : r_t2;
    assign w_hi        = r_t1 >> SH;
    assign w_trial_div = {r_rem, r_dlo[63]};
    assign w_div_ge    = (w_trial_div >= {1'b0, w_den});
    assign w_div_diff  = w_trial_div - {1'b0, w_den};

    // integer square root, one result bit per step
    logic [63:0] w_sq_trial, n_sres;
    logic        w_sq_ge;
    assign w_sq_trial = r_sres + r_sbit;
    assign w_sq_ge    = (r_sv >= w_sq_trial);
    assign n_sres     = w_sq_ge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);

    logic        w_root_done;
    logic [31:0] w_root_val;
    always_comb begin
        w_root_done = 1'b0;
        w_root_val  = '1;
        if ((r_state == ST_ROOT_LOAD) && (w_hi >= w_den)) begin
            w_root_done = 1'b1;
        end else if ((r_state == ST_SQRT) && (r_cnt == 7'd1)) begin
            w_root_done = 1'b1;
            w_root_val  = n_sres[31:0];
        end
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fit_len   <= wrts_pkg::FIT_LEN_RESET;
            r_fill      <= '0;
            r_wptr      <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_left      <= '0;
            r_op        <= '0;
            r_cnt       <= '0;
            r_root_sel  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fit_len <= i_cfg_wr_data;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            // summing pipeline: read, square, accumulate
            r_v1 <= w_rd_en;
            r_v2 <= r_v1;
            r_y2 <= r_rd_data;
            r_sq <= 64'(w_sq);
            if (r_v2) begin
                r_sy  <= w_sy_new;
                r_sxy <= r_sxy + {{(WXY - WY){w_sy_new[WY-1]}}, w_sy_new};
                r_syy <= r_syy + WYY'(r_sq);
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_wptr  <= n_wptr;
                        r_fill  <= n_fill;
                        r_n     <= w_neff;
                        r_left  <= w_neff;
                        r_raddr <= r_wptr;
                        r_k     <= '0;
                        r_xsq   <= '0;
                        r_sx    <= '0;
                        r_sxx   <= '0;
                        r_sy    <= '0;
                        r_sxy   <= '0;
                        r_syy   <= '0;
                        if (n_fill >= w_neff) begin
                            r_state <= ST_ACC;
                        end
                    end
                end
                ST_ACC: begin
                    if (w_rd_en) begin
                        r_left  <= r_left - LW'(1);
                        r_raddr <= (r_raddr == '0) ? PW'(MAX_WINDOW - 1) : r_raddr - PW'(1);
                        r_k     <= n_k;
                        r_xsq   <= n_xsq;
                        r_sx    <= r_sx + WSX'(n_k);
                        r_sxx   <= r_sxx + WSXX'(n_xsq);
                    end else if (!r_v1 && !r_v2) begin
                        r_op    <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (w_uop.kind == wrts_pkg::KIND_MUL) begin
                        r_ma    <= w_abs_a;
                        r_mb    <= w_abs_b;
                        r_mp    <= '0;
                        r_mneg  <= w_a[WD-1] ^ w_b[WD-1];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_mb != '0) begin
                        if (r_mb[0]) begin
                            r_mp <= r_mp + r_ma;
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                ST_ROOT_LOAD: begin
                    if (!w_root_done) begin
                        r_rem   <= w_hi;
                        r_dlo   <= {r_t1[SH-1:0], {(2 * FRAC_BITS){1'b0}}};
                        r_quo   <= '0;
                        r_cnt   <= 7'd64;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_div_ge ? w_div_diff[WD-1:0] : w_trial_div[WD-1:0];
                    r_dlo <= r_dlo << 1;
                    r_quo <= {r_quo[62:0], w_div_ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_sv    <= {r_quo[62:0], w_div_ge};
                        r_sres  <= '0;
                        r_sbit  <= 64'h4000_0000_0000_0000;
                        r_cnt   <= 7'd32;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (w_sq_ge) begin
                        r_sv <= r_sv - w_sq_trial;
                    end
                    r_sres <= n_sres;
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt - 7'd1;
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_ti    <= r_ti;
                        r_out_ts    <= r_ts;
                        r_out_pf    <= r_pf;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // result of a program step and what follows it
            if (w_op_done) begin
                case (w_uop.dst)
                    wrts_pkg::SRC_DD: r_dd <= w_op_res;
                    wrts_pkg::SRC_P:  r_p  <= w_op_res;
                    wrts_pkg::SRC_Q:  r_q  <= w_op_res;
                    wrts_pkg::SRC_T1: r_t1 <= w_op_res;
                    wrts_pkg::SRC_T2: r_t2 <= w_op_res;
                    wrts_pkg::SRC_NN: r_nn <= w_op_res;
                    default: ;
                endcase
                case (w_uop.after)
                    wrts_pkg::AFT_NEXT: begin
                        r_op    <= r_op + wrts_pkg::UOP_W'(1);
                        r_state <= ST_LOAD;
                    end
                    wrts_pkg::AFT_ZERO_CHECK: begin
                        if (w_op_res == '0) begin
                            // residual vanishes: both statistics saturate
                            r_ti    <= '1;
                            r_ts    <= '1;
                            r_pf    <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_op    <= r_op + wrts_pkg::UOP_W'(1);
                            r_state <= ST_LOAD;
                        end
                    end
                    wrts_pkg::AFT_ROOT_INTERCEPT: begin
                        r_root_sel <= 1'b0;
                        r_state    <= ST_ROOT_LOAD;
                    end
                    wrts_pkg::AFT_ROOT_SLOPE: begin
                        r_root_sel <= 1'b1;
                        r_state    <= ST_ROOT_LOAD;
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end

            // a finished root goes to its statistic
            if (w_root_done) begin
                if (!r_root_sel) begin
                    r_ti    <= w_root_val;
                    r_op    <= r_op + wrts_pkg::UOP_W'(1);
                    r_state <= ST_LOAD;
                end else begin
                    r_ts    <= w_root_val;
                    r_pf    <= 1'b0;
                    r_state <= ST_OUT;
                end
            end
        end
    end

endmodule
